// ===== src/gpiorb_pkg.sv =====
// Package for the GPIO register bank: sizes, register word codes, transfer types, helpers.
package gpiorb_pkg;

   localparam int PinCount  = 54;
   localparam int FselPins  = 10;
   localparam int FselWidth = 3;
   localparam int FselBits  = FselPins * FselWidth;
   localparam int FselNeed  = (PinCount + FselPins - 1) / FselPins;
   localparam int FselWords = (FselNeed > 7) ? 7 : FselNeed;
   localparam int FselIdxW  = $clog2(FselWords);

   localparam logic [5:0] AddrLastFsel = 6'd6;
   localparam logic [5:0] AddrSet0     = 6'd7;
   localparam logic [5:0] AddrSet1     = 6'd8;
   localparam logic [5:0] AddrClr0     = 6'd10;
   localparam logic [5:0] AddrClr1     = 6'd11;
   localparam logic [5:0] AddrLev0     = 6'd13;
   localparam logic [5:0] AddrLev1     = 6'd14;
   localparam logic [5:0] AddrPud      = 6'd37;
   localparam logic [5:0] AddrPudClk0  = 6'd38;
   localparam logic [5:0] AddrPudClk1  = 6'd39;

   localparam logic KindRead  = 1'b0;
   localparam logic KindWrite = 1'b1;

   localparam logic [FselWidth-1:0] FselOutput = 3'd1;

   typedef struct packed {
      logic                kind;
      logic [5:0]          address_word;
      logic [31:0]         write_data;
      logic [PinCount-1:0] pin_levels;
   } gpiorb_req_type;

   typedef struct packed {
      logic [31:0]         read_data;
      logic                bad_address;
      logic [PinCount-1:0] drive_level;
      logic [PinCount-1:0] drive_enable;
      logic [PinCount-1:0] pull_up_mask;
      logic [PinCount-1:0] pull_down_mask;
   } gpiorb_rsp_type;

   // fields of pins at or above PinCount are held at zero
   function automatic logic [FselBits-1:0] fsel_mask(input logic [FselIdxW-1:0] w);
      logic [FselBits-1:0] m;
      m = '0;
      for (int k = 0; k < FselPins; k++) begin
         if (int'(w) * FselPins + k < PinCount) begin
            m[k*FselWidth +: FselWidth] = '1;
         end
      end
      return m;
   endfunction

   function automatic logic [PinCount-1:0] bank_bits(input logic bank, input logic [31:0] d);
      logic [63:0] v;
      v = bank ? {d, 32'd0} : {32'd0, d};
      return v[PinCount-1:0];
   endfunction

   function automatic logic [31:0] bank_word(input logic bank, input logic [PinCount-1:0] pins);
      logic [63:0] v;
      v = 64'(pins);
      return bank ? v[63:32] : v[31:0];
   endfunction

endpackage

// ===== src/gpiorb_regfile.sv =====
// Register state and address decode of the GPIO register bank.
module gpiorb_regfile
   import gpiorb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  gpiorb_req_type req,
   output gpiorb_rsp_type rsp
);

   logic [FselBits-1:0] fsel_ff [FselWords];
   logic [FselBits-1:0] fsel_in [FselWords];
   logic [PinCount-1:0] latch_ff, latch_in;
   logic [1:0]          pull_code_ff, pull_code_in;
   logic [PinCount-1:0] pclk_ff, pclk_in;
   logic [PinCount-1:0] ps_lo_ff, ps_lo_in;
   logic [PinCount-1:0] ps_hi_ff, ps_hi_in;

   logic                wr;
   logic [5:0]          addr;
   logic [FselIdxW-1:0] fidx;
   logic [31:0]         rd;
   logic                bad;
   logic                bank;
   logic [PinCount-1:0] keep;
   logic [PinCount-1:0] rise;
   logic [PinCount-1:0] en;

   assign wr   = (req.kind == KindWrite);
   assign addr = req.address_word;
   assign fidx = addr[FselIdxW-1:0];
   assign bank = addr[0] ^ (addr == AddrPudClk1 || addr == AddrClr1 || addr == AddrSet1
                            || addr == AddrLev1 ? ~addr[0] : addr[0]);

   always_comb begin
      fsel_in      = fsel_ff;
      latch_in     = latch_ff;
      pull_code_in = pull_code_ff;
      pclk_in      = pclk_ff;
      ps_lo_in     = ps_lo_ff;
      ps_hi_in     = ps_hi_ff;
      rd           = '0;
      bad          = 1'b0;
      keep         = '0;
      rise         = '0;
      if (addr < 6'(FselWords)) begin
         if (wr) begin
            if (fire) fsel_in[fidx] = req.write_data[FselBits-1:0] & fsel_mask(fidx);
         end else begin
            rd = 32'(fsel_ff[fidx]);
         end
      end else if (addr <= AddrLastFsel) begin
         bad = 1'b1;
      end else begin
         case (addr)
            AddrSet0, AddrSet1: begin
               if (wr && fire) latch_in = latch_ff | bank_bits(bank, req.write_data);
            end
            AddrClr0, AddrClr1: begin
               if (wr && fire) latch_in = latch_ff & ~bank_bits(bank, req.write_data);
            end
            AddrLev0, AddrLev1: begin
               if (!wr) rd = bank_word(bank, req.pin_levels);
            end
            AddrPud: begin
               if (wr) begin
                  if (fire) pull_code_in = req.write_data[1:0];
               end else begin
                  rd = {30'd0, pull_code_ff};
               end
            end
            AddrPudClk0, AddrPudClk1: begin
               if (wr) begin
                  keep = bank_bits(~bank, '1);
                  rise = ((pclk_ff & keep) | bank_bits(bank, req.write_data)) & ~pclk_ff;
                  if (fire) begin
                     pclk_in  = (pclk_ff & keep) | bank_bits(bank, req.write_data);
                     ps_lo_in = (ps_lo_ff & ~rise) | (rise & {PinCount{pull_code_ff[0]}});
                     ps_hi_in = (ps_hi_ff & ~rise) | (rise & {PinCount{pull_code_ff[1]}});
                  end
               end else begin
                  rd = bank_word(bank, pclk_ff);
               end
            end
            default: bad = 1'b1;
         endcase
      end
   end

   for (genvar p = 0; p < PinCount; p++) begin : g_en
      assign en[p] = (fsel_in[p / FselPins][(p % FselPins) * FselWidth +: FselWidth]
                      == FselOutput);
   end

   always_comb begin
      rsp.read_data      = wr ? '0 : rd;
      rsp.bad_address    = bad;
      rsp.drive_level    = latch_in;
      rsp.drive_enable   = en;
      rsp.pull_up_mask   = ps_hi_in & ~ps_lo_in;
      rsp.pull_down_mask = ps_lo_in & ~ps_hi_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < FselWords; w++) fsel_ff[w] <= '0;
         latch_ff     <= '0;
         pull_code_ff <= '0;
         pclk_ff      <= '0;
         ps_lo_ff     <= '0;
         ps_hi_ff     <= '0;
      end else begin
         fsel_ff      <= fsel_in;
         latch_ff     <= latch_in;
         pull_code_ff <= pull_code_in;
         pclk_ff      <= pclk_in;
         ps_lo_ff     <= ps_lo_in;
         ps_hi_ff     <= ps_hi_in;
      end
   end

   // state moves only on a transfer
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(latch_ff) && $stable(pclk_ff) && $stable(pull_code_ff))
      else $error("gpiorb_regfile: state changed without a transfer");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.pull_up_mask & rsp.pull_down_mask) == '0)
      else $error("gpiorb_regfile: pin pulled both ways");
   assert property (@(posedge clock) disable iff (reset)
      bad |-> rsp.read_data == '0)
      else $error("gpiorb_regfile: unmapped word returned data");

endmodule

// ===== src/gpio_register_bank_core.sv =====
// Top level of the GPIO register bank: request register, register file, response register.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | gpiorb_req_type
//   rsp_    | out       | rsp_valid / rsp_ready | gpiorb_rsp_type
//
// One transfer per cycle sustained while rsp_ready is high.
// The request register feeds the register file, which updates state and forms the
// response in the same cycle that the response register loads.
// Reset clears all register state: every pin input, latch zero, pulls off.
// A stalled response holds the request register; req_ready drops only when both are full.
module gpio_register_bank_core
   import gpiorb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  gpiorb_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output gpiorb_rsp_type rsp_data
);

   logic           s1_valid_ff, s1_valid_in;
   gpiorb_req_type s1_req_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   gpiorb_rsp_type rsp_ff;
   gpiorb_rsp_type rsp_next;
   logic           advance;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   gpiorb_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (s1_req_ff),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) s1_req_ff <= req_data;
      if (advance) rsp_ff <= rsp_next;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("gpio_register_bank_core: response lost after advance");
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("gpio_register_bank_core: stalled request dropped");
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("gpio_register_bank_core: empty stage refused a transfer");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("gpio_register_bank_core: stalled response overwritten");

endmodule

// ===== tb/gpio_register_bank_core_tb.sv =====
// Self-checking GPIO register bank testbench: directed and random accesses, checked per transfer.
module gpio_register_bank_core_tb;
   import gpiorb_pkg::*;

   localparam int CycleLimit   = 200000;
   localparam int RandomCount  = 1375;
   localparam int CalmTail     = 150;
   localparam int DrainCycles  = 8;
   localparam logic [1:0] PullDown = 2'd1;
   localparam logic [1:0] PullUp   = 2'd2;
   localparam logic [1:0] PullRsvd = 2'd3;
   localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   gpiorb_req_type req_data  = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   gpiorb_rsp_type rsp_data;

   gpio_register_bank_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted register file
   logic [FselWidth-1:0] pin_function [PinCount];
   logic [1:0]           pin_pull     [PinCount];
   logic [PinCount-1:0]  latch_bits;
   logic [PinCount-1:0]  pudclk_bits;
   logic [1:0]           pull_code_q;

   gpiorb_req_type queued_access [$];
   gpiorb_rsp_type expected_view [$];
   gpiorb_rsp_type want;

   int  mismatches;
   int  accepted;
   int  checked;
   int  write_count;
   int  bad_count;
   int  pull_latches;
   int  cycle_count;
   int  req_gap;
   int  rsp_gap;
   bit  req_fire;
   bit  idling_on;

   function automatic logic [PinCount-1:0] bank_place(input logic hi, input logic [31:0] d);
      logic [63:0] wide;
      wide = hi ? {d, 32'd0} : {32'd0, d};
      return wide[PinCount-1:0];
   endfunction

   function automatic logic [31:0] bank_half(input logic hi, input logic [PinCount-1:0] pins);
      logic [63:0] wide;
      wide = 64'(pins);
      return hi ? wide[63:32] : wide[31:0];
   endfunction

   // applies one access to the predicted state and returns the response it yields
   function automatic gpiorb_rsp_type apply_access(input gpiorb_req_type a);
      gpiorb_rsp_type      r;
      logic [31:0]         rd;
      logic                bad;
      logic                wr;
      logic                hi;
      logic [PinCount-1:0] keep;
      logic [PinCount-1:0] nxt;
      logic [PinCount-1:0] rise;
      int                  pin;
      rd  = '0;
      bad = 1'b0;
      wr  = (a.kind == KindWrite);
      if (a.address_word <= AddrLastFsel) begin
         if (int'(a.address_word) * FselPins >= PinCount) begin
            bad = 1'b1;
         end else begin
            for (int k = 0; k < FselPins; k++) begin
               pin = int'(a.address_word) * FselPins + k;
               if (pin < PinCount) begin
                  if (wr) pin_function[pin] = a.write_data[k*FselWidth +: FselWidth];
                  else rd[k*FselWidth +: FselWidth] = pin_function[pin];
               end
            end
         end
      end else begin
         case (a.address_word)
            AddrSet0, AddrSet1: begin
               if (wr) latch_bits |= bank_place(a.address_word == AddrSet1, a.write_data);
            end
            AddrClr0, AddrClr1: begin
               if (wr) latch_bits &= ~bank_place(a.address_word == AddrClr1, a.write_data);
            end
            AddrLev0, AddrLev1: begin
               if (!wr) rd = bank_half(a.address_word == AddrLev1, a.pin_levels);
            end
            AddrPud: begin
               if (wr) pull_code_q = a.write_data[1:0];
               else rd = {30'd0, pull_code_q};
            end
            AddrPudClk0, AddrPudClk1: begin
               hi = (a.address_word == AddrPudClk1);
               if (wr) begin
                  keep = hi ? PinCount'(AllOnes) : ~PinCount'(AllOnes);
                  nxt  = (pudclk_bits & keep) | bank_place(hi, a.write_data);
                  rise = nxt & ~pudclk_bits;
                  for (int p = 0; p < PinCount; p++) begin
                     if (rise[p]) begin
                        pin_pull[p] = pull_code_q;
                        pull_latches++;
                     end
                  end
                  pudclk_bits = nxt;
               end else begin
                  rd = bank_half(hi, pudclk_bits);
               end
            end
            default: bad = 1'b1;
         endcase
      end
      r                = '0;
      r.read_data      = wr ? 32'd0 : rd;
      r.bad_address    = bad;
      r.drive_level    = latch_bits;
      for (int p = 0; p < PinCount; p++) begin
         r.drive_enable[p]   = (pin_function[p] == FselOutput);
         r.pull_up_mask[p]   = (pin_pull[p] == PullUp);
         r.pull_down_mask[p] = (pin_pull[p] == PullDown);
      end
      if (wr) write_count++;
      if (bad) bad_count++;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH at response %0d: %s", checked, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] exp);
      if (got !== exp) report_mismatch($sformatf("%s got %h expected %h", name, got, exp));
   endtask

   function automatic logic [PinCount-1:0] random_levels();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return wide[PinCount-1:0];
      endcase
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return AllOnes;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [5:0] random_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 6'($urandom_range(0, int'(AddrLastFsel)));
      if (r < 38) return ($urandom_range(0, 1) != 0) ? AddrSet1 : AddrSet0;
      if (r < 46) return ($urandom_range(0, 1) != 0) ? AddrClr1 : AddrClr0;
      if (r < 54) return ($urandom_range(0, 1) != 0) ? AddrLev1 : AddrLev0;
      if (r < 62) return AddrPud;
      if (r < 80) return ($urandom_range(0, 1) != 0) ? AddrPudClk1 : AddrPudClk0;
      return 6'($urandom_range(0, 63));
   endfunction

   task automatic queue_access(input logic kind, input logic [5:0] addr,
                               input logic [31:0] data, input logic [PinCount-1:0] levels);
      gpiorb_req_type a;
      a.kind         = kind;
      a.address_word = addr;
      a.write_data   = data;
      a.pin_levels   = levels;
      queued_access.push_back(a);
   endtask

   initial begin
      for (int p = 0; p < PinCount; p++) begin
         pin_function[p] = '0;
         pin_pull[p]     = '0;
      end
      latch_bits  = '0;
      pudclk_bits = '0;
      pull_code_q = '0;

      // directed: field extremes, write-only and read-only words, pull latching, bad words
      queue_access(KindWrite, 6'd0, AllOnes, random_levels());
      queue_access(KindRead, 6'd0, random_word(), random_levels());
      queue_access(KindWrite, 6'd5, AllOnes, random_levels());
      queue_access(KindRead, 6'd5, random_word(), random_levels());
      queue_access(KindWrite, AddrLastFsel, AllOnes, random_levels());
      queue_access(KindRead, AddrLastFsel, random_word(), random_levels());
      queue_access(KindWrite, 6'd0, 32'h0924_9249, random_levels());
      queue_access(KindWrite, 6'd5, 32'h0000_0249, random_levels());
      queue_access(KindWrite, AddrSet0, AllOnes, random_levels());
      queue_access(KindWrite, AddrSet1, AllOnes, random_levels());
      queue_access(KindRead, AddrSet0, random_word(), random_levels());
      queue_access(KindWrite, AddrClr0, 32'h5555_5555, random_levels());
      queue_access(KindWrite, AddrClr1, AllOnes, random_levels());
      queue_access(KindRead, AddrClr1, random_word(), random_levels());
      queue_access(KindRead, AddrLev0, random_word(), '1);
      queue_access(KindRead, AddrLev1, random_word(), '1);
      queue_access(KindWrite, AddrLev0, AllOnes, '1);
      queue_access(KindWrite, AddrPud, 32'd2, random_levels());
      queue_access(KindWrite, AddrPudClk0, AllOnes, random_levels());
      queue_access(KindWrite, AddrPud, 32'd1, random_levels());
      queue_access(KindWrite, AddrPudClk1, AllOnes, random_levels());
      queue_access(KindWrite, AddrPud, {30'd0, PullRsvd}, random_levels());
      queue_access(KindWrite, AddrPudClk0, 32'd0, random_levels());
      queue_access(KindWrite, AddrPudClk0, 32'h0000_FFFF, random_levels());
      queue_access(KindRead, AddrPud, random_word(), random_levels());
      queue_access(KindRead, AddrPudClk1, random_word(), random_levels());
      queue_access(KindRead, '1, random_word(), random_levels());
      queue_access(KindWrite, '1, AllOnes, random_levels());

      for (int n = 0; n < RandomCount; ) begin
         if ($urandom_range(0, 9) < 3) begin
            // pull update: code then clock bank write
            queue_access(KindWrite, AddrPud, random_word(), random_levels());
            queue_access(KindWrite, ($urandom_range(0, 1) != 0) ? AddrPudClk1 : AddrPudClk0,
                         random_word(), random_levels());
            n += 2;
         end else begin
            queue_access(1'($urandom_range(0, 1)), random_address(), random_word(),
                         random_levels());
            n++;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_access.size() > 0 || req_valid) @(posedge clock);
      while (expected_view.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (expected_view.size() > 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_view.size()));

      $display("Ran %0d bus accesses (%0d writes, %0d to unmapped words), %0d responses checked.",
               accepted, write_count, bad_count, checked);
      $display("Pull state latched on %0d pin edges; %0d mismatches.", pull_latches, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // request driver and response ready, both at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         idling_on = (queued_access.size() >= CalmTail) && ((accepted / 96) % 3 != 2);
         if (!req_valid || req_fire) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (queued_access.size() > 0) begin
               req_data  <= queued_access.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // accepted requests feed the predictor; accepted responses are checked in order
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_view.push_back(apply_access(req_data));
            accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_view.size() == 0) begin
               report_mismatch("response transfer with nothing expected");
            end else begin
               want = expected_view.pop_front();
               check_field("read_data", 64'(rsp_data.read_data), 64'(want.read_data));
               check_field("bad_address", 64'(rsp_data.bad_address), 64'(want.bad_address));
               check_field("drive_level", 64'(rsp_data.drive_level), 64'(want.drive_level));
               check_field("drive_enable", 64'(rsp_data.drive_enable), 64'(want.drive_enable));
               check_field("pull_up_mask", 64'(rsp_data.pull_up_mask), 64'(want.pull_up_mask));
               check_field("pull_down_mask", 64'(rsp_data.pull_down_mask),
                           64'(want.pull_down_mask));
            end
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_view.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
